// ----- hw/rtl/uvs_pkg.sv -----
// Package for the UV sphere wireframe vertex generator.
// Constants, CORDIC arctangent table, register indexes. No dependencies.
package uvs_pkg;
    localparam int CORDIC_STEPS = 30;
    localparam int MAX_GRID_DEF = 256;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    typedef enum logic [2:0] {
        REG_CX = 3'd0, REG_CY = 3'd1, REG_CZ = 3'd2, REG_RAD = 3'd3,
        REG_COLS = 3'd4, REG_ROWS = 3'd5, REG_COLOR = 3'd6, REG_NONE = 3'd7
    } reg_idx_t;

    // one CORDIC lane word handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [1:0]         quad;
    } cordic_lane_t;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0: v = 34'sd536870912;  5'd1: v = 34'sd316933406;
            5'd2: v = 34'sd167458907;  5'd3: v = 34'sd85004756;
            5'd4: v = 34'sd42667331;   5'd5: v = 34'sd21354465;
            5'd6: v = 34'sd10679838;   5'd7: v = 34'sd5340245;
            5'd8: v = 34'sd2670163;    5'd9: v = 34'sd1335087;
            5'd10: v = 34'sd667544;    5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;    5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;     5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;     5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;      5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;       5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;       5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;        5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;        5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;         5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction
endpackage

// ----- hw/rtl/uvs_cordic_cell.sv -----
// One rotation step of the CORDIC chain; passes its lane word to the next cell.
// Depends on uvs_pkg.
module uvs_cordic_cell import uvs_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  cordic_lane_t lane_in,
    output cordic_lane_t lane_out
);
    localparam logic [4:0] STEP_IDX = 5'(STEP);
    cordic_lane_t lane_reg, lane_next;
    logic signed [33:0] xs, ys, at;

    always_comb begin
        xs = lane_in.x >>> STEP;
        ys = lane_in.y >>> STEP;
        at = atan_turn(STEP_IDX);
        lane_next = lane_in;
        if (!lane_in.z[33]) begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - at;
        end else begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.vld <= 1'b0;
        end else if (adv) begin
            lane_reg.vld <= lane_next.vld;
        end
        if (adv) begin
            lane_reg.x <= lane_next.x;
            lane_reg.y <= lane_next.y;
            lane_reg.z <= lane_next.z;
            lane_reg.quad <= lane_next.quad;
        end
    end

    assign lane_out = lane_reg;
endmodule

// ----- hw/rtl/uvs_sincos.sv -----
// Sine/cosine unit: a chain of CORDIC cells plus quadrant fold and clamp.
// Depends on uvs_pkg and uvs_cordic_cell.
module uvs_sincos import uvs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic [31:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);
    cordic_lane_t chain [CORDIC_STEPS+1];
    logic signed [33:0] xc, yc;

    always_comb begin
        chain[0].vld  = 1'b1;
        chain[0].x    = CORDIC_K;
        chain[0].y    = '0;
        chain[0].z    = {4'b0, phase[29:0]};
        chain[0].quad = phase[31:30];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        uvs_cordic_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .lane_in(chain[i]), .lane_out(chain[i+1])
        );
    end

    always_comb begin
        xc = chain[CORDIC_STEPS].x;
        yc = chain[CORDIC_STEPS].y;
        if (xc > ONE_Q30) xc = ONE_Q30;
        if (xc < -ONE_Q30) xc = -ONE_Q30;
        if (yc > ONE_Q30) yc = ONE_Q30;
        if (yc < -ONE_Q30) yc = -ONE_Q30;
        unique case (chain[CORDIC_STEPS].quad)
            2'd0: begin sin_q30 = 32'(yc);  cos_q30 = 32'(xc);  end
            2'd1: begin sin_q30 = 32'(xc);  cos_q30 = 32'(-yc); end
            2'd2: begin sin_q30 = 32'(-yc); cos_q30 = 32'(-xc); end
            default: begin sin_q30 = 32'(-xc); cos_q30 = 32'(yc); end
        endcase
    end
endmodule

// ----- hw/rtl/uv_sphere_wireframe_vertex_gen.sv -----
// UV sphere wireframe vertex generator, top level. Depends on uvs_pkg, uvs_sincos.
// Each cell word becomes four vertex words; a new cell is accepted only as the previous
// cell's last vertex request issues (the four vertices share one result port); vertices
// issue one per cycle unless an output stall freezes the pipe. Path from cell accept to
// vertex: 43 divider stages, 30-cell CORDIC chain, two multiply stages, output register.
// Reset (aresetn low, synchronous) restores register defaults and empties the pipe.
module uv_sphere_wireframe_vertex_gen import uvs_pkg::*; #(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cell_col[7:0], cell_row[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [127:0] m_tdata,  // pos_x, pos_y, pos_z, vertex_color
    output logic        m_tlast,   // last_vertex
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int GW = $clog2(MAX_GRID + 1);
    localparam int NW = GW + 34;
    localparam int DIVS = NW;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] rad_reg;
    logic [8:0]  cols_reg, rows_reg;
    logic [31:0] color_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            rad_reg <= 31'd65536; cols_reg <= 9'd16; rows_reg <= 9'd16;
            color_reg <= '1;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CX:    cx_reg <= cfg_data;
                REG_CY:    cy_reg <= cfg_data;
                REG_CZ:    cz_reg <= cfg_data;
                REG_RAD:   rad_reg <= cfg_data[30:0];
                REG_COLS:  cols_reg <= cfg_data[8:0];
                REG_ROWS:  rows_reg <= cfg_data[8:0];
                REG_COLOR: color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective counts
    logic [GW-1:0] nc, nr;
    always_comb begin
        nc = (cols_reg == 9'd0) ? GW'(1) :
             ({23'b0, cols_reg} > MAX_GRID) ? GW'(MAX_GRID) : GW'(cols_reg);
        nr = (rows_reg == 9'd0) ? GW'(1) :
             ({23'b0, rows_reg} > MAX_GRID) ? GW'(MAX_GRID) : GW'(rows_reg);
    end

    // pipe advance: stall whole pipe while output holds an untaken word
    logic adv;
    assign adv = !m_tvalid || m_tready;

    // input sequencer: emits four vertex requests per cell
    logic [1:0] seq_reg;
    logic       busy_reg;
    logic [GW-1:0] col_reg, row_reg;
    assign s_tready = adv && (!busy_reg || seq_reg == 2'd3);

    logic [GW-1:0] cin, rin;
    always_comb begin
        cin = (16'(s_tdata[7:0]) >= 16'(nc)) ? nc - GW'(1) : GW'(s_tdata[7:0]);
        rin = (16'(s_tdata[15:8]) >= 16'(nr)) ? nr - GW'(1) : GW'(s_tdata[15:8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seq_reg <= '0;
        end else if (adv) begin
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
                seq_reg <= '0;
            end else if (busy_reg) begin
                seq_reg <= seq_reg + 2'd1;
                if (seq_reg == 2'd3) busy_reg <= 1'b0;
            end
        end
        if (adv && s_tvalid && s_tready) begin
            col_reg <= cin;
            row_reg <= rin;
        end
    end

    // request per vertex: ring k, column k, last flag
    logic          rq_vld;
    logic [GW-1:0] rq_rk, rq_ck;
    logic          rq_last;
    always_comb begin
        rq_vld = busy_reg;
        rq_rk = row_reg;
        rq_ck = col_reg;
        rq_last = 1'b0;
        unique case (seq_reg)
            2'd1: rq_ck = col_reg + GW'(1);
            2'd3: begin rq_rk = row_reg + GW'(1); rq_last = 1'b1; end
            default: ;
        endcase
    end

    // phase numerators: rk*2^31 + nr/2, ck*2^32 + nc/2 ; restoring division chain
    typedef struct packed {
        logic          vld;
        logic          last;
        logic [NW-1:0] rrem, crem;
        logic [NW-1:0] rq, cq;
    } div_t;
    div_t dv [DIVS+1];
    always_comb begin
        dv[0].vld  = rq_vld;
        dv[0].last = rq_last;
        dv[0].rrem = '0;
        dv[0].crem = '0;
        dv[0].rq = (NW'(rq_rk) << 31) + NW'(nr >> 1);
        dv[0].cq = (NW'(rq_ck) << 32) + NW'(nc >> 1);
    end
    for (genvar i = 0; i < DIVS; i++) begin : g_div
        div_t n;
        logic [NW-1:0] rt, ct;
        always_comb begin
            n = dv[i];
            rt = {dv[i].rrem[NW-2:0], dv[i].rq[NW-1]};
            ct = {dv[i].crem[NW-2:0], dv[i].cq[NW-1]};
            n.rq = {dv[i].rq[NW-2:0], 1'b0};
            n.cq = {dv[i].cq[NW-2:0], 1'b0};
            if (rt >= NW'(nr)) begin n.rrem = rt - NW'(nr); n.rq[0] = 1'b1; end
            else n.rrem = rt;
            if (ct >= NW'(nc)) begin n.crem = ct - NW'(nc); n.cq[0] = 1'b1; end
            else n.crem = ct;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) dv[i+1].vld <= 1'b0;
            else if (adv) dv[i+1].vld <= n.vld;
            if (adv) begin
                dv[i+1].last <= n.last;
                dv[i+1].rrem <= n.rrem; dv[i+1].crem <= n.crem;
                dv[i+1].rq <= n.rq; dv[i+1].cq <= n.cq;
            end
        end
    end

    // CORDIC chains for ring and column angle
    logic signed [31:0] st, ct_q, sa, ca;
    uvs_sincos u_ring (.aclk(aclk), .aresetn(aresetn), .adv(adv),
        .phase(dv[DIVS].rq[31:0]), .sin_q30(st), .cos_q30(ct_q));
    uvs_sincos u_col (.aclk(aclk), .aresetn(aresetn), .adv(adv),
        .phase(dv[DIVS].cq[31:0]), .sin_q30(sa), .cos_q30(ca));

    logic [CORDIC_STEPS-1:0] cv_reg, cl_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) cv_reg <= '0;
        else if (adv) cv_reg <= {cv_reg[CORDIC_STEPS-2:0], dv[DIVS].vld};
        if (adv) cl_reg <= {cl_reg[CORDIC_STEPS-2:0], dv[DIVS].last};
    end

    // stage 1: r*st, r*ct
    logic signed [63:0] p_rr, p_h;
    logic signed [31:0] sa1_reg, ca1_reg;
    logic signed [33:0] rr_reg, rh_reg;
    logic v1_reg, l1_reg;
    always_comb begin
        p_rr = $signed({1'b0, rad_reg}) * st + 64'sd536870912;
        p_h  = $signed({1'b0, rad_reg}) * ct_q + 64'sd536870912;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= cv_reg[CORDIC_STEPS-1];
        if (adv) begin
            l1_reg <= cl_reg[CORDIC_STEPS-1];
            rr_reg <= 34'(p_rr >>> 30);
            rh_reg <= 34'(p_h >>> 30);
            sa1_reg <= sa; ca1_reg <= ca;
        end
    end

    // stage 2: rr*sa, rr*ca, height
    logic signed [65:0] p_x, p_z;
    logic signed [34:0] hx_reg, xx_reg, zz_reg;
    logic v2_reg, l2_reg;
    always_comb begin
        p_x = rr_reg * sa1_reg + 66'sd536870912;
        p_z = rr_reg * ca1_reg + 66'sd536870912;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            l2_reg <= l1_reg;
            xx_reg <= 35'(p_x >>> 30) + 35'(cx_reg);
            zz_reg <= 35'(p_z >>> 30) + 35'(cz_reg);
            hx_reg <= 35'(cy_reg) - 35'(rh_reg);
        end
    end

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -35'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (adv) m_tvalid <= v2_reg;
        if (adv) begin
            m_tdata <= {color_reg, sat32(zz_reg), sat32(hx_reg), sat32(xx_reg)};
            m_tlast <= l2_reg;
        end
    end
endmodule
